// ===== design/mmhq_pkg.sv =====
// shared types, constants and helpers for the min-max heap queue
`timescale 1ns / 1ps
package mmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 16;
  localparam int TAG_W    = 16;
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CAND_W   = IDX_W + 2;
  localparam int ENT_W    = KEY_BITS + TAG_W;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INS,
    OP_UP_P,
    OP_UP_G,
    OP_UP_GC,
    OP_RD_ROOT,
    OP_ROOT_D,
    OP_DEL,
    OP_DEL_R,
    OP_DEL_L,
    OP_DN_CHK,
    OP_DN_ISS,
    OP_DN_CMP,
    OP_DN_DEC,
    OP_DN_CW,
    OP_DN_GP,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic mode_del;
    logic full;
    logic empty;
    logic fill_nz;
    logic idx_ge4;
    logic g_move;
    logic has_child;
    logic cand_ok;
    logic m_gc;
    logic m_lt_x;
    logic out_free;
  } stat_t;

  // true when the heap index sits on an even (min) level
  function automatic logic on_min_level(input logic [IDX_W-1:0] v);
    logic odd;
    odd = 1'b0;
    for (int b = 0; b < IDX_W; b++) begin
      if (v[b]) begin
        odd = b[0];
      end
    end
    return !odd;
  endfunction

endpackage

// ===== design/min_max_heap_queue.sv =====
// top level of the min-max heap queue
`timescale 1ns / 1ps
// Min-max heap of 1024 key/tag entries. A word with mode 0 inserts its key and tag, mode 1
// removes the minimum; each word gives one result word with status, a key, its tag and the
// entry count. The heap lives in one memory with a registered read, so every compare waits
// for its read, and that sets the rate: an insert takes longer for each grandparent level
// it climbs, a delete for each grandchild level it descends. The next word is taken once
// the current one has finished and the controller is back in idle; the finished result
// waits in an output register.
module min_max_heap_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [15:0] entry_key_i,
  input  logic [15:0] entry_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_key_o,
  output logic [15:0] out_tag_o,
  output logic [10:0] entry_count_o
);

  mmhq_pkg::cmd_t  cmd;
  mmhq_pkg::stat_t stat;

  mmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mmhq_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_i),
    .entry_key_i   (entry_key_i),
    .entry_tag_i   (entry_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_tag_o     (out_tag_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ===== design/mmhq_ctrl.sv =====
// sequencer for insert trickle up and delete trickle down
`timescale 1ns / 1ps
module mmhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mmhq_pkg::stat_t stat_i,
  output mmhq_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_START   = 5'd1;
  localparam logic [4:0] S_INS     = 5'd2;
  localparam logic [4:0] S_UP_P    = 5'd3;
  localparam logic [4:0] S_UP_G    = 5'd4;
  localparam logic [4:0] S_UP_GC   = 5'd5;
  localparam logic [4:0] S_RD_ROOT = 5'd6;
  localparam logic [4:0] S_ROOT_D  = 5'd7;
  localparam logic [4:0] S_DEL     = 5'd8;
  localparam logic [4:0] S_DEL_R   = 5'd9;
  localparam logic [4:0] S_DEL_L   = 5'd10;
  localparam logic [4:0] S_DN_CHK  = 5'd11;
  localparam logic [4:0] S_DN_ISS  = 5'd12;
  localparam logic [4:0] S_DN_CMP  = 5'd13;
  localparam logic [4:0] S_DN_DEC  = 5'd14;
  localparam logic [4:0] S_DN_CW   = 5'd15;
  localparam logic [4:0] S_DN_GP   = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;

  logic [4:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = mmhq_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mmhq_pkg::OP_ACCEPT;
          state_d  = S_START;
        end
      end
      S_START: begin
        state_d = stat_i.mode_del ? S_DEL : S_INS;
      end
      S_INS: begin
        cmd_o.op = mmhq_pkg::OP_INS;
        if (stat_i.full) begin
          state_d = S_RD_ROOT;
        end else if (stat_i.fill_nz) begin
          state_d = S_UP_P;
        end else begin
          state_d = S_UP_G;
        end
      end
      S_UP_P: begin
        cmd_o.op = mmhq_pkg::OP_UP_P;
        state_d  = S_UP_G;
      end
      S_UP_G: begin
        cmd_o.op = mmhq_pkg::OP_UP_G;
        state_d  = stat_i.idx_ge4 ? S_UP_GC : S_RD_ROOT;
      end
      S_UP_GC: begin
        cmd_o.op = mmhq_pkg::OP_UP_GC;
        state_d  = stat_i.g_move ? S_UP_G : S_RD_ROOT;
      end
      S_RD_ROOT: begin
        cmd_o.op = mmhq_pkg::OP_RD_ROOT;
        state_d  = S_ROOT_D;
      end
      S_ROOT_D: begin
        cmd_o.op = mmhq_pkg::OP_ROOT_D;
        state_d  = S_DONE;
      end
      S_DEL: begin
        cmd_o.op = mmhq_pkg::OP_DEL;
        state_d  = stat_i.empty ? S_DONE : S_DEL_R;
      end
      S_DEL_R: begin
        cmd_o.op = mmhq_pkg::OP_DEL_R;
        state_d  = S_DEL_L;
      end
      S_DEL_L: begin
        cmd_o.op = mmhq_pkg::OP_DEL_L;
        state_d  = S_DN_CHK;
      end
      S_DN_CHK: begin
        cmd_o.op = mmhq_pkg::OP_DN_CHK;
        state_d  = stat_i.has_child ? S_DN_ISS : S_DONE;
      end
      S_DN_ISS: begin
        cmd_o.op = mmhq_pkg::OP_DN_ISS;
        state_d  = stat_i.cand_ok ? S_DN_CMP : S_DN_DEC;
      end
      S_DN_CMP: begin
        cmd_o.op = mmhq_pkg::OP_DN_CMP;
        state_d  = S_DN_ISS;
      end
      S_DN_DEC: begin
        cmd_o.op = mmhq_pkg::OP_DN_DEC;
        if (!stat_i.m_lt_x) begin
          state_d = S_DONE;
        end else begin
          state_d = stat_i.m_gc ? S_DN_GP : S_DN_CW;
        end
      end
      S_DN_CW: begin
        cmd_o.op = mmhq_pkg::OP_DN_CW;
        state_d  = S_DONE;
      end
      S_DN_GP: begin
        cmd_o.op = mmhq_pkg::OP_DN_GP;
        state_d  = S_DN_CHK;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = mmhq_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/mmhq_datapath.sv =====
// heap memory, moving entry, candidate search and result register
`timescale 1ns / 1ps
module mmhq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmhq_pkg::cmd_t                      cmd_i,
  output mmhq_pkg::stat_t                     stat_o,
  input  logic                                mode_i,
  input  logic [15:0]                         entry_key_i,
  input  logic [15:0]                         entry_tag_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [15:0]                         out_key_o,
  output logic [15:0]                         out_tag_o,
  output logic [10:0]                         entry_count_o
);

  localparam int KW = mmhq_pkg::KEY_BITS;
  localparam int TW = mmhq_pkg::TAG_W;
  localparam int IW = mmhq_pkg::IDX_W;
  localparam int AW = mmhq_pkg::ADDR_W;
  localparam int CW = mmhq_pkg::CAND_W;
  localparam int EW = mmhq_pkg::ENT_W;

  logic [EW-1:0] mem_q [mmhq_pkg::CAPACITY];
  logic [EW-1:0] rdata_q;

  logic          we, re;
  logic [IW-1:0] wa_idx, ra_idx;
  logic [EW-1:0] wdata;
  logic [AW-1:0] waddr, raddr;

  logic          mode_q, mode_d;
  logic [IW-1:0] fill_q, fill_d, idx_q, idx_d, m_idx_q, m_idx_d;
  logic [KW-1:0] x_key_q, x_key_d, m_key_q, m_key_d, c0_key_q, c0_key_d, c1_key_q, c1_key_d;
  logic [TW-1:0] x_tag_q, x_tag_d, m_tag_q, m_tag_d, c0_tag_q, c0_tag_d, c1_tag_q, c1_tag_d;
  logic          dir_max_q, dir_max_d, m_gc_q, m_gc_d;
  logic [2:0]    k_q, k_d;
  logic [CW-1:0] cand_q, cand_d, cand;
  logic [KW-1:0] res_key_q, res_key_d;
  logic [TW-1:0] res_tag_q, res_tag_d;
  logic [1:0]    res_st_q, res_st_d;

  logic          ov_q, ov_d;
  logic [1:0]    o_st_q, o_st_d;
  logic [KW-1:0] o_key_q, o_key_d;
  logic [TW-1:0] o_tag_q, o_tag_d;
  logic [IW-1:0] o_cnt_q, o_cnt_d;

  logic [KW-1:0] rd_key, p_key;
  logic [TW-1:0] rd_tag, p_tag;
  logic [IW-1:0] fill_inc, m_half;
  logic          is_min, up_mv, g_mv;

  assign rd_key   = rdata_q[EW-1:TW];
  assign rd_tag   = rdata_q[TW-1:0];
  assign fill_inc = fill_q + IW'(1);
  assign m_half   = m_idx_q >> 1;
  assign p_key    = m_idx_q[1] ? c1_key_q : c0_key_q;
  assign p_tag    = m_idx_q[1] ? c1_tag_q : c0_tag_q;
  assign is_min   = mmhq_pkg::on_min_level(idx_q);
  assign up_mv    = is_min ? (x_key_q > rd_key) : (x_key_q < rd_key);
  assign g_mv     = dir_max_q ? (x_key_q > rd_key) : (x_key_q < rd_key);
  assign cand     = (k_q < 3'd2) ? ({1'b0, idx_q, 1'b0} + CW'(k_q))
                                 : ({idx_q, 2'b00} + CW'(k_q) - CW'(2));

  assign waddr = AW'(wa_idx - IW'(1));
  assign raddr = AW'(ra_idx - IW'(1));

  assign stat_o.mode_del  = mode_q;
  assign stat_o.full      = (fill_q == IW'(mmhq_pkg::CAPACITY));
  assign stat_o.empty     = (fill_q == '0);
  assign stat_o.fill_nz   = (fill_q != '0);
  assign stat_o.idx_ge4   = (idx_q >= IW'(4));
  assign stat_o.g_move    = g_mv;
  assign stat_o.has_child = ({1'b0, idx_q, 1'b0} <= CW'(fill_q));
  assign stat_o.cand_ok   = (k_q <= 3'd5) && (cand <= CW'(fill_q));
  assign stat_o.m_gc      = m_gc_q;
  assign stat_o.m_lt_x    = (m_key_q < x_key_q);
  assign stat_o.out_free  = !ov_q || !out_stall_i;

  always_comb begin
    mode_d    = mode_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    m_idx_d   = m_idx_q;
    x_key_d   = x_key_q;
    x_tag_d   = x_tag_q;
    m_key_d   = m_key_q;
    m_tag_d   = m_tag_q;
    c0_key_d  = c0_key_q;
    c0_tag_d  = c0_tag_q;
    c1_key_d  = c1_key_q;
    c1_tag_d  = c1_tag_q;
    dir_max_d = dir_max_q;
    m_gc_d    = m_gc_q;
    k_d       = k_q;
    cand_d    = cand_q;
    res_key_d = res_key_q;
    res_tag_d = res_tag_q;
    res_st_d  = res_st_q;
    o_st_d    = o_st_q;
    o_key_d   = o_key_q;
    o_tag_d   = o_tag_q;
    o_cnt_d   = o_cnt_q;
    ov_d      = ov_q && out_stall_i;
    we        = 1'b0;
    re        = 1'b0;
    wa_idx    = idx_q;
    ra_idx    = idx_q;
    wdata     = {x_key_q, x_tag_q};
    unique case (cmd_i.op)
      mmhq_pkg::OP_NONE: begin
      end
      mmhq_pkg::OP_ACCEPT: begin
        mode_d  = mode_i;
        x_key_d = entry_key_i[KW-1:0];
        x_tag_d = entry_tag_i;
      end
      mmhq_pkg::OP_INS: begin
        if (stat_o.full) begin
          res_st_d = mmhq_pkg::ST_FULL;
        end else begin
          res_st_d = mmhq_pkg::ST_DONE;
          fill_d   = fill_inc;
          idx_d    = fill_inc;
          re       = 1'b1;
          ra_idx   = fill_inc >> 1;
        end
      end
      mmhq_pkg::OP_UP_P: begin
        dir_max_d = is_min ? up_mv : !up_mv;
        if (up_mv) begin
          we    = 1'b1;
          wdata = rdata_q;
          idx_d = idx_q >> 1;
        end
      end
      mmhq_pkg::OP_UP_G: begin
        if (stat_o.idx_ge4) begin
          re     = 1'b1;
          ra_idx = idx_q >> 2;
        end else begin
          we = 1'b1;
        end
      end
      mmhq_pkg::OP_UP_GC: begin
        we = 1'b1;
        if (g_mv) begin
          wdata = rdata_q;
          idx_d = idx_q >> 2;
        end
      end
      mmhq_pkg::OP_RD_ROOT: begin
        re     = 1'b1;
        ra_idx = IW'(1);
      end
      mmhq_pkg::OP_ROOT_D: begin
        res_key_d = rd_key;
        res_tag_d = rd_tag;
      end
      mmhq_pkg::OP_DEL: begin
        res_key_d = '0;
        res_tag_d = '0;
        res_st_d  = stat_o.empty ? mmhq_pkg::ST_EMPTY : mmhq_pkg::ST_DONE;
        re        = !stat_o.empty;
        ra_idx    = IW'(1);
      end
      mmhq_pkg::OP_DEL_R: begin
        res_key_d = rd_key;
        res_tag_d = rd_tag;
        re        = 1'b1;
        ra_idx    = fill_q;
      end
      mmhq_pkg::OP_DEL_L: begin
        x_key_d = rd_key;
        x_tag_d = rd_tag;
        fill_d  = fill_q - IW'(1);
        idx_d   = IW'(1);
      end
      mmhq_pkg::OP_DN_CHK: begin
        k_d = '0;
        we  = !stat_o.has_child;
      end
      mmhq_pkg::OP_DN_ISS: begin
        if (stat_o.cand_ok) begin
          re     = 1'b1;
          ra_idx = IW'(cand);
          cand_d = cand;
        end
      end
      mmhq_pkg::OP_DN_CMP: begin
        if ((k_q == 3'd0) || (rd_key < m_key_q)) begin
          m_idx_d = IW'(cand_q);
          m_key_d = rd_key;
          m_tag_d = rd_tag;
          m_gc_d  = (k_q >= 3'd2);
        end
        if (k_q == 3'd0) begin
          c0_key_d = rd_key;
          c0_tag_d = rd_tag;
        end
        if (k_q == 3'd1) begin
          c1_key_d = rd_key;
          c1_tag_d = rd_tag;
        end
        k_d = k_q + 3'd1;
      end
      mmhq_pkg::OP_DN_DEC: begin
        we = 1'b1;
        if (stat_o.m_lt_x) begin
          wdata = {m_key_q, m_tag_q};
        end
      end
      mmhq_pkg::OP_DN_CW: begin
        we     = 1'b1;
        wa_idx = m_idx_q;
      end
      mmhq_pkg::OP_DN_GP: begin
        idx_d = m_idx_q;
        if (x_key_q > p_key) begin
          we      = 1'b1;
          wa_idx  = m_half;
          x_key_d = p_key;
          x_tag_d = p_tag;
        end
      end
      mmhq_pkg::OP_OUT: begin
        ov_d    = 1'b1;
        o_st_d  = res_st_q;
        o_key_d = res_key_q;
        o_tag_d = res_tag_q;
        o_cnt_d = fill_q;
      end
      default: begin
      end
    endcase
  end

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    idx_q     <= idx_d;
    m_idx_q   <= m_idx_d;
    x_key_q   <= x_key_d;
    x_tag_q   <= x_tag_d;
    m_key_q   <= m_key_d;
    m_tag_q   <= m_tag_d;
    c0_key_q  <= c0_key_d;
    c0_tag_q  <= c0_tag_d;
    c1_key_q  <= c1_key_d;
    c1_tag_q  <= c1_tag_d;
    dir_max_q <= dir_max_d;
    m_gc_q    <= m_gc_d;
    k_q       <= k_d;
    cand_q    <= cand_d;
    res_key_q <= res_key_d;
    res_tag_q <= res_tag_d;
    res_st_q  <= res_st_d;
    o_st_q    <= o_st_d;
    o_key_q   <= o_key_d;
    o_tag_q   <= o_tag_d;
    o_cnt_q   <= o_cnt_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = o_st_q;
  assign out_key_o     = 16'(o_key_q);
  assign out_tag_o     = o_tag_q;
  assign entry_count_o = 11'(o_cnt_q);

endmodule
